[hw/rtl/osl_pkg.sv]
// ----------------------------------------------------------------------------
// osl_pkg
// Shared types and constants of the object section stream loader: section
// ids, address regions, status codes, parser phases and section kinds.
// ----------------------------------------------------------------------------
package osl_pkg;

	// section ids, big-endian on the stream
	localparam logic [15:0] ID_LINE = 16'h715E;
	localparam logic [15:0] ID_FILE = 16'hF17E;
	localparam logic [15:0] ID_SYM  = 16'hC3B7;
	localparam logic [15:0] ID_CODE = 16'hCADE;
	localparam logic [15:0] ID_DATA = 16'hDADA;

	// address region bounds
	localparam logic [15:0] LOW_CODE_END   = 16'h3FFF;
	localparam logic [15:0] LOW_DATA_BASE  = 16'h4000;
	localparam logic [15:0] LOW_DATA_END   = 16'h7FFF;
	localparam logic [15:0] HIGH_CODE_BASE = 16'h8000;
	localparam logic [15:0] HIGH_CODE_END  = 16'h9FFF;
	localparam logic [15:0] HIGH_DATA_BASE = 16'hA000;

	// bytes skipped by a line-number section
	localparam logic [15:0] LINE_SKIP_LEN = 16'd6;

	// load status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_WRITE    = 3'd0;
	localparam status_t ST_OK       = 3'd1;
	localparam status_t ST_BAD_ID   = 3'd2;
	localparam status_t ST_BAD_CODE = 3'd3;
	localparam status_t ST_BAD_DATA = 3'd4;
	localparam status_t ST_TRUNC    = 3'd5;
	localparam status_t ST_NONE     = 3'd0;

	// parser phase, one-hot
	typedef enum logic [9:0] {
		PH_ID_HI   = 10'b00_0000_0001,
		PH_ID_LO   = 10'b00_0000_0010,
		PH_ADDR_HI = 10'b00_0000_0100,
		PH_ADDR_LO = 10'b00_0000_1000,
		PH_LEN_HI  = 10'b00_0001_0000,
		PH_LEN_LO  = 10'b00_0010_0000,
		PH_SKIP    = 10'b00_0100_0000,
		PH_BODY_HI = 10'b00_1000_0000,
		PH_BODY_LO = 10'b01_0000_0000,
		PH_HALT    = 10'b10_0000_0000
	} phase_t;

	// section kind
	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_LINE = 3'd1,
		KIND_FILE = 3'd2,
		KIND_SYM  = 3'd3,
		KIND_CODE = 3'd4,
		KIND_DATA = 3'd5
	} kind_t;

endpackage

[hw/rtl/object_section_stream_loader.sv]
// ----------------------------------------------------------------------------
// object_section_stream_loader
// Parses an object file one byte per transaction and emits memory word
// writes, address and id errors, and a final load status.
// ----------------------------------------------------------------------------
// The loader takes one byte (or a stream end mark) per clock cycle while
// in_stall is low. The parser state and the running totals are updated at
// acceptance, and any result is captured in a single output register on
// the same clock edge. in_stall is raised only while that output register
// holds a result the consumer is stalling. Bytes that produce no
// result (section headers, skipped bytes, the high byte of a body word,
// anything after an error) vanish without an output transaction. A stream
// end always yields one result carrying the final status and the code and
// data word totals, and returns the loader to its reset state for the next
// file.
module object_section_stream_loader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        write_enable,
	output logic [15:0] write_addr,
	output logic [15:0] write_data,
	output logic [2:0]  load_status,
	output logic [31:0] code_words_total,
	output logic [31:0] data_words_total
);
	import osl_pkg::*;

	// parser state
	phase_t      phase_q, phase_d;
	logic [7:0]  hold_q, hold_d;
	kind_t       kind_q, kind_d;
	logic [15:0] addr_q, addr_d;
	logic [15:0] left_q, left_d;
	logic [31:0] code_total_q, code_total_d;
	logic [31:0] data_total_q, data_total_d;
	status_t     error_q, error_d;

	// result of the current transaction
	logic        res_valid;
	logic        res_we;
	logic [15:0] res_addr;
	logic [15:0] res_data;
	status_t     res_status;

	logic        in_accept;
	logic [15:0] word;
	logic [15:0] left_dec;
	logic        code_bad;
	logic        data_bad;
	logic [32:0] total_sum;
	logic [31:0] total_sat;

	// output register
	logic        out_valid_q;
	logic        we_q;
	logic [15:0] waddr_q;
	logic [15:0] wdata_q;
	status_t     status_q;
	logic [31:0] code_out_q;
	logic [31:0] data_out_q;

	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;

	// datapath helpers
	assign word     = {hold_q, data_byte};
	assign left_dec = (left_q != 16'd0) ? left_q - 16'd1 : left_q;
	assign code_bad = ((word >= LOW_DATA_BASE) && (word <= LOW_DATA_END))
		|| (word >= HIGH_DATA_BASE);
	assign data_bad = (word <= LOW_CODE_END)
		|| ((word >= HIGH_CODE_BASE) && (word <= HIGH_CODE_END));
	assign total_sum = (kind_q == KIND_CODE)
		? {1'b0, code_total_q} + {17'd0, word}
		: {1'b0, data_total_q} + {17'd0, word};
	assign total_sat = total_sum[32] ? '1 : total_sum[31:0];

	// next state and result for one transaction
	always_comb begin
		phase_d      = phase_q;
		hold_d       = hold_q;
		kind_d       = kind_q;
		addr_d       = addr_q;
		left_d       = left_q;
		code_total_d = code_total_q;
		data_total_d = data_total_q;
		error_d      = error_q;
		res_valid    = 1'b0;
		res_we       = 1'b0;
		res_addr     = 16'd0;
		res_data     = 16'd0;
		res_status   = ST_WRITE;
		if (stream_end) begin
			res_valid = 1'b1;
			if (error_q != ST_NONE) begin
				res_status = error_q;
			end else if (phase_q == PH_ID_HI || phase_q == PH_ID_LO) begin
				res_status = ST_OK;
			end else begin
				res_status = ST_TRUNC;
			end
			phase_d      = PH_ID_HI;
			hold_d       = 8'd0;
			kind_d       = KIND_NONE;
			addr_d       = 16'd0;
			left_d       = 16'd0;
			code_total_d = 32'd0;
			data_total_d = 32'd0;
			error_d      = ST_NONE;
		end else begin
			unique case (phase_q)
				PH_ID_HI, PH_ADDR_HI, PH_LEN_HI, PH_BODY_HI: begin
					hold_d = data_byte;
					unique case (phase_q)
						PH_ID_HI:   phase_d = PH_ID_LO;
						PH_ADDR_HI: phase_d = PH_ADDR_LO;
						PH_LEN_HI:  phase_d = PH_LEN_LO;
						default:    phase_d = PH_BODY_LO;
					endcase
				end
				PH_ID_LO: begin
					priority if (word == ID_LINE) begin
						kind_d  = KIND_LINE;
						left_d  = LINE_SKIP_LEN;
						phase_d = PH_SKIP;
					end else if (word == ID_FILE) begin
						kind_d  = KIND_FILE;
						phase_d = PH_LEN_HI;
					end else if (word == ID_SYM) begin
						kind_d  = KIND_SYM;
						phase_d = PH_ADDR_HI;
					end else if (word == ID_CODE) begin
						kind_d  = KIND_CODE;
						phase_d = PH_ADDR_HI;
					end else if (word == ID_DATA) begin
						kind_d  = KIND_DATA;
						phase_d = PH_ADDR_HI;
					end else begin
						error_d    = ST_BAD_ID;
						phase_d    = PH_HALT;
						res_valid  = 1'b1;
						res_status = ST_BAD_ID;
					end
				end
				PH_ADDR_LO: begin
					if (kind_q == KIND_CODE && code_bad) begin
						error_d    = ST_BAD_CODE;
						phase_d    = PH_HALT;
						res_valid  = 1'b1;
						res_status = ST_BAD_CODE;
					end else if (kind_q == KIND_DATA && data_bad) begin
						error_d    = ST_BAD_DATA;
						phase_d    = PH_HALT;
						res_valid  = 1'b1;
						res_status = ST_BAD_DATA;
					end else begin
						addr_d  = word;
						phase_d = PH_LEN_HI;
					end
				end
				PH_LEN_LO: begin
					left_d = word;
					if (kind_q == KIND_CODE || kind_q == KIND_DATA) begin
						if (kind_q == KIND_CODE) begin
							code_total_d = total_sat;
						end else begin
							data_total_d = total_sat;
						end
						phase_d = (word == 16'd0) ? PH_ID_HI : PH_BODY_HI;
					end else begin
						phase_d = (word == 16'd0) ? PH_ID_HI : PH_SKIP;
					end
				end
				PH_SKIP: begin
					left_d = left_dec;
					if (left_dec == 16'd0) begin
						phase_d = PH_ID_HI;
					end
				end
				PH_BODY_LO: begin
					addr_d    = addr_q + 16'd1;
					left_d    = left_dec;
					phase_d   = (left_dec == 16'd0) ? PH_ID_HI : PH_BODY_HI;
					res_valid = 1'b1;
					res_we    = 1'b1;
					res_addr  = addr_q;
					res_data  = word;
				end
				PH_HALT: begin
					phase_d = PH_HALT;
				end
				default: begin
					phase_d = PH_ID_HI;
				end
			endcase
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_ID_HI;
			hold_q       <= 8'd0;
			kind_q       <= KIND_NONE;
			addr_q       <= 16'd0;
			left_q       <= 16'd0;
			code_total_q <= 32'd0;
			data_total_q <= 32'd0;
			error_q      <= ST_NONE;
		end else if (in_accept) begin
			phase_q      <= phase_d;
			hold_q       <= hold_d;
			kind_q       <= kind_d;
			addr_q       <= addr_d;
			left_q       <= left_d;
			code_total_q <= code_total_d;
			data_total_q <= data_total_d;
			error_q      <= error_d;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload, totals as they stand before any stream end clear
	always_ff @(posedge clk) begin
		if (in_accept && res_valid) begin
			we_q       <= res_we;
			waddr_q    <= res_addr;
			wdata_q    <= res_data;
			status_q   <= res_status;
			code_out_q <= code_total_q;
			data_out_q <= data_total_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign write_enable     = we_q;
	assign write_addr       = waddr_q;
	assign write_data       = wdata_q;
	assign load_status      = status_q;
	assign code_words_total = code_out_q;
	assign data_words_total = data_out_q;

	// a write transaction always carries the write status
	a_write_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && we_q |-> status_q == ST_WRITE)
		else $error("write transaction with non-write status");

	// a latched error keeps the parser halted
	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		error_q != ST_NONE |-> phase_q == PH_HALT)
		else $error("error latched while parser still running");

	// a stream end leaves the parser in its reset state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && stream_end |=> phase_q == PH_ID_HI && error_q == ST_NONE
			&& code_total_q == 32'd0 && data_total_q == 32'd0)
		else $error("stream end did not clear parser state");

	// totals only grow within one load
	a_code_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && !stream_end |=> code_total_q >= $past(code_total_q))
		else $error("code total decreased within a load");

	// status never exceeds the truncated code
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> status_q <= ST_TRUNC)
		else $error("status code out of range");

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for object_section_stream_loader. It feeds object files
// as byte streams: every section kind, bad ids and addresses, odd trailing
// bytes, truncation and random files. A built-in parser predicts each memory
// write and each final status. Every result is checked field by field while
// both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import osl_pkg::*;

	typedef struct packed {
		logic        we;
		logic [15:0] addr;
		logic [15:0] data;
		status_t     status;
		logic [31:0] code_sum;
		logic [31:0] data_sum;
	} load_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        stream_end;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        write_enable;
	logic [15:0] write_addr;
	logic [15:0] write_data;
	logic [2:0]  load_status;
	logic [31:0] code_words_total;
	logic [31:0] data_words_total;

	// parser state mirrored by the bench
	phase_t      p_phase;
	kind_t       p_kind;
	logic [7:0]  p_hold;
	logic [15:0] p_addr;
	logic [15:0] p_left;
	logic [31:0] p_code;
	logic [31:0] p_data;
	status_t     p_err;

	load_result_t pending_results[$];
	int unsigned  fault_count = 0;
	int unsigned  live_items = 0;
	int unsigned  send_idle_pct = 0;
	int unsigned  stall_pct = 0;
	int unsigned  hold_cycles = 0;

	object_section_stream_loader DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic void reset_parser();
		p_phase = PH_ID_HI;
		p_kind  = KIND_NONE;
		p_hold  = '0;
		p_addr  = '0;
		p_left  = '0;
		p_code  = '0;
		p_data  = '0;
		p_err   = ST_NONE;
	endfunction

	// advance the parser by one transaction, return 1 when a result is due
	function automatic bit parse_byte(input logic [7:0] b, input logic fin,
			output load_result_t r);
		logic [15:0] word;
		logic [32:0] sum;
		status_t     fault;
		bit          has;
		r     = '0;
		fault = ST_NONE;
		has   = 1'b0;
		// stream end reports status and totals, then starts over
		if (fin) begin
			r.code_sum = p_code;
			r.data_sum = p_data;
			if (p_err != ST_NONE)
				r.status = p_err;
			else if (p_phase == PH_ID_HI || p_phase == PH_ID_LO)
				r.status = ST_OK;
			else
				r.status = ST_TRUNC;
			reset_parser();
			return 1'b1;
		end
		word = {p_hold, b};
		case (p_phase)
			PH_ID_HI: begin
				p_hold  = b;
				p_phase = PH_ID_LO;
			end
			PH_ID_LO: begin
				case (word)
					ID_LINE: begin
						p_kind  = KIND_LINE;
						p_left  = LINE_SKIP_LEN;
						p_phase = PH_SKIP;
					end
					ID_FILE: begin
						p_kind  = KIND_FILE;
						p_phase = PH_LEN_HI;
					end
					ID_SYM: begin
						p_kind  = KIND_SYM;
						p_phase = PH_ADDR_HI;
					end
					ID_CODE: begin
						p_kind  = KIND_CODE;
						p_phase = PH_ADDR_HI;
					end
					ID_DATA: begin
						p_kind  = KIND_DATA;
						p_phase = PH_ADDR_HI;
					end
					default: fault = ST_BAD_ID;
				endcase
			end
			PH_ADDR_HI: begin
				p_hold  = b;
				p_phase = PH_ADDR_LO;
			end
			PH_LEN_HI: begin
				p_hold  = b;
				p_phase = PH_LEN_LO;
			end
			PH_BODY_HI: begin
				p_hold  = b;
				p_phase = PH_BODY_LO;
			end
			// region check for code and data
			PH_ADDR_LO: begin
				if (p_kind == KIND_CODE && ((word >= LOW_DATA_BASE && word <= LOW_DATA_END)
						|| word >= HIGH_DATA_BASE))
					fault = ST_BAD_CODE;
				else if (p_kind == KIND_DATA && (word <= LOW_CODE_END
						|| (word >= HIGH_CODE_BASE && word <= HIGH_CODE_END)))
					fault = ST_BAD_DATA;
				else begin
					p_addr  = word;
					p_phase = PH_LEN_HI;
				end
			end
			// length, with saturating totals for code and data
			PH_LEN_LO: begin
				p_left = word;
				if (p_kind == KIND_CODE || p_kind == KIND_DATA) begin
					if (p_kind == KIND_CODE) begin
						sum    = {1'b0, p_code} + {17'd0, word};
						p_code = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					end else begin
						sum    = {1'b0, p_data} + {17'd0, word};
						p_data = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					end
					p_phase = (word == 16'd0) ? PH_ID_HI : PH_BODY_HI;
				end else
					p_phase = (word == 16'd0) ? PH_ID_HI : PH_SKIP;
			end
			PH_SKIP: begin
				if (p_left != 16'd0)
					p_left = p_left - 16'd1;
				if (p_left == 16'd0)
					p_phase = PH_ID_HI;
			end
			// one memory write per body word, address wraps
			PH_BODY_LO: begin
				r.we     = 1'b1;
				r.addr   = p_addr;
				r.data   = word;
				r.status = ST_WRITE;
				p_addr   = p_addr + 16'd1;
				if (p_left != 16'd0)
					p_left = p_left - 16'd1;
				p_phase  = (p_left == 16'd0) ? PH_ID_HI : PH_BODY_HI;
				has      = 1'b1;
			end
			default: ;
		endcase
		if (fault != ST_NONE) begin
			p_err    = fault;
			p_phase  = PH_HALT;
			r.status = fault;
			has      = 1'b1;
		end
		r.code_sum = p_code;
		r.data_sum = p_data;
		return has;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			fault_count++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		load_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d addr %0h",
					$time, load_status, write_addr);
				fault_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("write_enable", 32'(want.we), 32'(write_enable));
				check_field("write_addr", 32'(want.addr), 32'(write_addr));
				check_field("write_data", 32'(want.data), 32'(write_data));
				check_field("load_status", 32'(want.status), 32'(load_status));
				check_field("code_words_total", want.code_sum, code_words_total);
				check_field("data_words_total", want.data_sum, data_words_total);
			end
		end
	end

	// receiver: long hold-off when asked, else random stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// offer one transaction and wait for it to be taken
	task automatic send_item(input logic [7:0] b, input logic fin);
		load_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		stream_end <= fin;
		do
			@(posedge clk);
		while (in_stall);
		live_items++;
		if (parse_byte(b, fin, res))
			pending_results.push_back(res);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(b, 1'b0);
	endtask

	task automatic send_word(input logic [15:0] w);
		send_byte(w[15:8]);
		send_byte(w[7:0]);
	endtask

	task automatic send_end();
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	// stop offering and wait for every expected result
	task automatic wait_results_done();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [15:0] id_of(kind_t k);
		case (k)
			KIND_LINE: return ID_LINE;
			KIND_FILE: return ID_FILE;
			KIND_SYM:  return ID_SYM;
			KIND_DATA: return ID_DATA;
			default:   return ID_CODE;
		endcase
	endfunction

	// whole section with random content
	task automatic send_section(input kind_t k, input logic [15:0] addr, input logic [15:0] len);
		send_word(id_of(k));
		case (k)
			KIND_LINE: repeat (LINE_SKIP_LEN) send_byte(8'($urandom_range(255)));
			KIND_FILE: begin
				send_word(len);
				repeat (len) send_byte(8'($urandom_range(255)));
			end
			KIND_SYM: begin
				send_word(addr);
				send_word(len);
				repeat (len) send_byte(8'($urandom_range(255)));
			end
			default: begin
				send_word(addr);
				send_word(len);
				repeat (len) send_word(16'($urandom_range(65535)));
			end
		endcase
	endtask

	// mostly legal addresses, often region bounds, sometimes anything
	function automatic logic [15:0] pick_addr(kind_t k);
		int unsigned r;
		r = $urandom_range(9);
		if (r < 2 || k == KIND_SYM)
			return 16'($urandom_range(65535));
		if (r < 5)
			case ($urandom_range(7))
				0: return 16'h0000;
				1: return LOW_CODE_END;
				2: return LOW_DATA_BASE;
				3: return LOW_DATA_END;
				4: return HIGH_CODE_BASE;
				5: return HIGH_CODE_END;
				6: return HIGH_DATA_BASE;
				default: return 16'hFFFF;
			endcase
		if (k == KIND_DATA)
			return $urandom_range(1) ? 16'($urandom_range(LOW_DATA_BASE, LOW_DATA_END))
				: 16'($urandom_range(HIGH_DATA_BASE, 16'hFFFF));
		return $urandom_range(1) ? 16'($urandom_range(0, LOW_CODE_END))
			: 16'($urandom_range(HIGH_CODE_BASE, HIGH_CODE_END));
	endfunction

	function automatic logic [15:0] pick_len();
		int unsigned r;
		r = $urandom_range(19);
		if (r == 0)
			return 16'd0;
		if (r == 1)
			return 16'($urandom_range(10, 40));
		return 16'($urandom_range(1, 6));
	endfunction

	task automatic send_random_section();
		int unsigned r;
		kind_t       k;
		logic [15:0] w;
		r = $urandom_range(99);
		if (r < 6) begin
			// bad id, sometimes sharing the high byte of a real one
			w = 16'($urandom_range(65535));
			if (r < 3)
				w[15:8] = 8'(id_of(kind_t'($urandom_range(1, 5))) >> 8);
			if (w == ID_LINE || w == ID_FILE || w == ID_SYM || w == ID_CODE || w == ID_DATA)
				w[0] = ~w[0];
			send_word(w);
			return;
		end
		if (r < 18)
			k = KIND_LINE;
		else if (r < 32)
			k = KIND_FILE;
		else if (r < 46)
			k = KIND_SYM;
		else if (r < 73)
			k = KIND_CODE;
		else
			k = KIND_DATA;
		send_section(k, pick_addr(k), pick_len());
	endtask

	// one object file: sections, then a clean, odd or truncated end
	task automatic send_random_file();
		int unsigned r;
		kind_t       k;
		r = $urandom_range(99);
		if (r < 6) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
			send_end();
			return;
		end
		repeat ($urandom_range(1, 5)) send_random_section();
		r = $urandom_range(9);
		if (r == 0)
			send_byte(8'($urandom_range(255)));
		else if (r == 1) begin
			send_word(id_of(kind_t'($urandom_range(1, 5))));
			repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)));
		end else if (r == 2) begin
			k = $urandom_range(1) ? KIND_CODE : KIND_DATA;
			send_word(id_of(k));
			send_word(pick_addr(k));
			send_word(16'($urandom_range(100, 65535)));
			repeat ($urandom_range(1, 4)) send_word(16'($urandom_range(65535)));
		end
		send_end();
		if ($urandom_range(9) == 0)
			wait_results_done();
	endtask

	// each section kind, zero lengths, word extremes
	task automatic test_sections();
		send_section(KIND_LINE, 16'h0000, 16'd0);
		send_word(ID_FILE);
		send_word(16'd0);
		send_section(KIND_FILE, 16'h0000, 16'd2);
		send_section(KIND_SYM, 16'hFFFF, 16'd1);
		send_word(ID_CODE);
		send_word(LOW_CODE_END);
		send_word(16'd2);
		send_word(16'h0000);
		send_word(16'hFFFF);
		send_section(KIND_DATA, HIGH_DATA_BASE, 16'd0);
		send_end();
	endtask

	// bad id, bad code address, bad data address, bytes ignored afterwards
	task automatic test_errors();
		send_word(16'h0000);
		send_byte(8'hFF);
		send_end();
		send_section(KIND_CODE, LOW_DATA_BASE, 16'd1);
		send_end();
		send_word(ID_DATA);
		send_word(HIGH_CODE_END);
		send_end();
	endtask

	// empty stream, odd trailing byte, truncated body
	task automatic test_stream_end();
		send_end();
		send_section(KIND_LINE, 16'h0000, 16'd0);
		send_byte(ID_CODE[15:8]);
		send_end();
		send_word(ID_CODE);
		send_word(HIGH_CODE_BASE);
		send_word(16'd3);
		send_word(16'h1234);
		send_end();
	endtask

	// write address wraps past the top of memory
	task automatic test_wrap();
		send_section(KIND_DATA, 16'hFFFF, 16'd2);
		send_end();
	endtask

	// receiver holds off while the sender keeps offering body words
	task automatic test_pressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_cycles   = 200;
		send_section(KIND_CODE, HIGH_CODE_BASE, 16'd30);
		wait_results_done();
		send_end();
		wait_results_done();
	endtask

	task automatic test_random();
		int unsigned goal;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 59; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 59; end
				default: begin send_idle_pct = 21; stall_pct = 21; end
			endcase
			goal = live_items + 362;
			while (live_items < goal)
				send_random_file();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		data_byte  = '0;
		stream_end = 1'b0;
		reset_parser();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 21;
		stall_pct     = 21;
		test_sections();
		test_errors();
		test_stream_end();
		test_wrap();
		test_pressure();
		test_random();
		wait_results_done();

		if (fault_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/osl_pkg.sv
hw/rtl/object_section_stream_loader.sv
test/testbench.sv
